>>> hdl/qcqd_pkg.sv
package qcqd_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int VEC_W       = 8;
  localparam int IDX_W       = 2;
  localparam int IDX_RANGE   = 1 << IDX_W;
  localparam int OUT_CH      = 4;
  localparam int OUT_CNT_W   = 32;

  localparam logic [2:0] PH_IDLE = 3'd4;

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_FWD     = 2'd1,
    DIR_REV     = 2'd2
  } dir_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_RESET  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VEC_W-1:0]   encoder_bits;
    logic [IDX_W-1:0]   motor_index;
    logic               clear_count;
  } in_t;

  typedef struct packed {
    logic                        changed;
    logic [1:0]                  dir_0;
    logic [1:0]                  dir_1;
    logic [1:0]                  dir_2;
    logic [1:0]                  dir_3;
    logic signed [OUT_CNT_W-1:0] count_0;
    logic signed [OUT_CNT_W-1:0] count_1;
    logic signed [OUT_CNT_W-1:0] count_2;
    logic signed [OUT_CNT_W-1:0] count_3;
  } out_t;

  typedef struct packed {
    logic sample;
    logic reset_ch;
    logic clear;
  } lane_ctrl_t;

  // forward Gray order: 00 -> 10 -> 11 -> 01 -> 00
  function automatic logic [1:0] fwd_next(input logic [1:0] ph);
    logic [1:0] r;
    unique case (ph)
      2'b00:   r = 2'b10;
      2'b10:   r = 2'b11;
      2'b11:   r = 2'b01;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic signed [OUT_CNT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] ext;
    ext = 64'(signed'(c));
    return ext[OUT_CNT_W-1:0];
  endfunction

endpackage

>>> hdl/qcqd_lane.sv
module qcqd_lane
  import qcqd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_ctrl_t             ctrl_i,
  input  logic [1:0]             val_i,
  output dir_e                   dir_o,
  output logic [COUNT_WIDTH-1:0] count_o
);

  logic [2:0]             phase_q, phase_d;
  dir_e                   dir_q, dir_d;
  logic [COUNT_WIDTH-1:0] pos_q, pos_d;

  always_comb begin
    phase_d = phase_q;
    dir_d   = dir_q;
    pos_d   = pos_q;
    if (ctrl_i.sample) begin
      if ({1'b0, val_i} != phase_q) begin
        priority if (phase_q == PH_IDLE) begin
          phase_d = {1'b0, val_i};
          dir_d   = DIR_UNKNOWN;
        end else if (fwd_next(phase_q[1:0]) == val_i) begin
          phase_d = {1'b0, val_i};
          dir_d   = DIR_FWD;
          pos_d   = pos_q + COUNT_WIDTH'(1);
        end else if (fwd_next(val_i) == phase_q[1:0]) begin
          phase_d = {1'b0, val_i};
          dir_d   = DIR_REV;
          pos_d   = pos_q - COUNT_WIDTH'(1);
        end else begin
          // two-step jump: lose lock, keep count
          phase_d = PH_IDLE;
          dir_d   = DIR_UNKNOWN;
        end
      end
    end else if (ctrl_i.reset_ch) begin
      phase_d = PH_IDLE;
      dir_d   = DIR_UNKNOWN;
      if (ctrl_i.clear) begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dir_q   <= DIR_UNKNOWN;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      pos_q   <= pos_d;
    end
  end

  assign dir_o   = dir_d;
  assign count_o = pos_d;

endmodule

>>> hdl/qcqd_merge.sv
module qcqd_merge
  import qcqd_pkg::*;
(
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  logic                                 sample_i,
  input  logic [VEC_W-1:0]                     vec_i,
  input  dir_e                                 lane_dir_i [CHANNELS],
  input  logic [CHANNELS-1:0][COUNT_WIDTH-1:0] lane_cnt_i,
  output logic                                 full_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output out_t                                 out_data_o
);

  logic [VEC_W-1:0] last_q;
  logic [1:0]                  dir_pad [OUT_CH];
  logic signed [OUT_CNT_W-1:0] cnt_pad [OUT_CH];
  out_t res;
  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_free;

  for (genvar i = 0; i < OUT_CH; i++) begin : g_pad
    if (i < CHANNELS) begin : g_lane
      assign dir_pad[i] = lane_dir_i[i];
      assign cnt_pad[i] = to_out(lane_cnt_i[i]);
    end else begin : g_none
      assign dir_pad[i] = DIR_UNKNOWN;
      assign cnt_pad[i] = '0;
    end
  end

  always_comb begin
    res.changed = sample_i && (vec_i != last_q);
    res.dir_0   = dir_pad[0];
    res.dir_1   = dir_pad[1];
    res.dir_2   = dir_pad[2];
    res.dir_3   = dir_pad[3];
    res.count_0 = cnt_pad[0];
    res.count_1 = cnt_pad[1];
    res.count_2 = cnt_pad[2];
    res.count_3 = cnt_pad[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (take_i && sample_i) begin
      last_q <= vec_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= take_i;
      end else begin
        out_valid_q  <= take_i;
      end
    end else if (take_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (take_i) begin
          skid_q <= res;
        end
      end else if (take_i) begin
        out_q <= res;
      end
    end else if (take_i) begin
      skid_q <= res;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/quad_channel_quadrature_decoder.sv
// Four-channel x4 quadrature decoder. One transaction per clock is accepted when not stalled;
// each gives exactly one result, held in the output register or, if that is stalled, first in
// the skid register. Each channel lane updates its phase, direction and count in the cycle of
// acceptance; a result register plus a skid register let input keep flowing while a result
// waits, and in_stall_o rises only when both hold results the downstream side has not taken.
module quad_channel_quadrature_decoder
  import qcqd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic                                 take;
  logic                                 full;
  logic                                 sample;
  dir_e                                 lane_dir [CHANNELS];
  logic [CHANNELS-1:0][COUNT_WIDTH-1:0] lane_cnt;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;
  assign sample     = in_data_i.op == OP_SAMPLE;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lane_ctrl_t ctrl;
    logic [1:0] val;

    if (2 * i < VEC_W) begin : g_pins
      assign val = in_data_i.encoder_bits[2*i +: 2];
    end else begin : g_nopins
      assign val = 2'b00;
    end

    if (i < IDX_RANGE) begin : g_idx
      assign ctrl.reset_ch = take && !sample && (in_data_i.motor_index == IDX_W'(i));
    end else begin : g_noidx
      assign ctrl.reset_ch = 1'b0;
    end
    assign ctrl.sample = take && sample;
    assign ctrl.clear  = in_data_i.clear_count;

    qcqd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .val_i   (val),
      .dir_o   (lane_dir[i]),
      .count_o (lane_cnt[i])
    );
  end

  qcqd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .sample_i    (sample),
    .vec_i       (in_data_i.encoder_bits),
    .lane_dir_i  (lane_dir),
    .lane_cnt_i  (lane_cnt),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/qcqd_checker.sv
module qcqd_checker
  import qcqd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // stall only when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> out_valid_o)
    else $error("accepted transaction gave no result");

  a_reset_op_unchanged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o && in_data_i.op == OP_RESET)
      |=> !out_data_o.changed)
    else $error("channel reset flagged a change");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.dir_0 == DIR_UNKNOWN || out_data_o.dir_0 == DIR_FWD ||
                     out_data_o.dir_0 == DIR_REV))
    else $error("bad direction code on channel 0");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind quad_channel_quadrature_decoder qcqd_checker u_qcqd_checker (.*);

>>> tb/sv/tb_qcqd_monitor.sv
module tb_qcqd_monitor
  import qcqd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   mismatches_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // successor in forward Gray order, two bits per pin value
  localparam logic [7:0] SUCC_LUT = {2'd1, 2'd3, 2'd0, 2'd2};

  logic [2:0]             ch_phase [CHANNELS];
  dir_e                   ch_dir   [CHANNELS];
  logic [COUNT_WIDTH-1:0] ch_count [CHANNELS];
  logic [VEC_W-1:0]       prev_vector;
  out_t                   predicted_readings [$];

  assign pending_o = predicted_readings.size();

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : decode_track
    out_t       want;
    logic [1:0] pin;
    logic [1:0] cur;
    int         m;
    if (!rst_ni) begin
      for (m = 0; m < CHANNELS; m++) begin
        ch_phase[m] = PH_IDLE;
        ch_dir[m]   = DIR_UNKNOWN;
        ch_count[m] = '0;
      end
      prev_vector  = '0;
      mismatches_o = 0;
      predicted_readings.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_readings.size() == 0) begin
          $display("%0t unexpected transaction: expected none, actual %h", $time, out_data_i);
          mismatches_o++;
        end else begin
          want = predicted_readings.pop_front();
          compare_field("changed", 32'(want.changed), 32'(out_data_i.changed));
          compare_field("dir_0", 32'(want.dir_0), 32'(out_data_i.dir_0));
          compare_field("dir_1", 32'(want.dir_1), 32'(out_data_i.dir_1));
          compare_field("dir_2", 32'(want.dir_2), 32'(out_data_i.dir_2));
          compare_field("dir_3", 32'(want.dir_3), 32'(out_data_i.dir_3));
          compare_field("count_0", want.count_0, out_data_i.count_0);
          compare_field("count_1", want.count_1, out_data_i.count_1);
          compare_field("count_2", want.count_2, out_data_i.count_2);
          compare_field("count_3", want.count_3, out_data_i.count_3);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = '0;
        if (in_data_i.op == OP_SAMPLE) begin
          want.changed = (in_data_i.encoder_bits != prev_vector);
          prev_vector  = in_data_i.encoder_bits;
          for (m = 0; m < CHANNELS; m++) begin
            pin = in_data_i.encoder_bits[2*m +: 2];
            cur = ch_phase[m][1:0];
            if ({1'b0, pin} == ch_phase[m]) begin
            end else if (ch_phase[m] == PH_IDLE) begin
              ch_phase[m] = {1'b0, pin};
              ch_dir[m]   = DIR_UNKNOWN;
            end else if (SUCC_LUT[2*cur +: 2] == pin) begin
              ch_phase[m] = {1'b0, pin};
              ch_dir[m]   = DIR_FWD;
              ch_count[m] = ch_count[m] + COUNT_WIDTH'(1);
            end else if (SUCC_LUT[2*pin +: 2] == cur) begin
              ch_phase[m] = {1'b0, pin};
              ch_dir[m]   = DIR_REV;
              ch_count[m] = ch_count[m] - COUNT_WIDTH'(1);
            end else begin
              ch_phase[m] = PH_IDLE;
              ch_dir[m]   = DIR_UNKNOWN;
            end
          end
        end else if (int'(in_data_i.motor_index) < CHANNELS) begin
          ch_phase[in_data_i.motor_index] = PH_IDLE;
          ch_dir[in_data_i.motor_index]   = DIR_UNKNOWN;
          if (in_data_i.clear_count) begin
            ch_count[in_data_i.motor_index] = '0;
          end
        end
        want.dir_0   = ch_dir[0];
        want.dir_1   = ch_dir[1];
        want.dir_2   = ch_dir[2];
        want.dir_3   = ch_dir[3];
        want.count_0 = ch_count[0];
        want.count_1 = ch_count[1];
        want.count_2 = ch_count[2];
        want.count_3 = ch_count[3];
        predicted_readings.push_back(want);
      end
    end
  end

endmodule

>>> tb/sv/tb_quad_channel_quadrature_decoder.sv
module tb_quad_channel_quadrature_decoder;
  import qcqd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SEG_ITEMS    = 225;
  localparam int HOLD_CYCLES  = 50;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  int   idle_pct = 0;
  bit   hold_req = 1'b0;
  int   mismatches;
  int   pending;

  always #1 clk_i = ~clk_i;

  quad_channel_quadrature_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  tb_qcqd_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  task automatic offer(input op_e op, input logic [7:0] pins, input logic [1:0] motor,
                       input logic clr);
    in_t t;
    t.op           = op;
    t.encoder_bits = pins;
    t.motor_index  = motor;
    t.clear_count  = clr;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] walk_pos [CHANNELS];
    logic [7:0] pins;
    int         seg;
    int         n;
    int         m;
    int         r;
    for (m = 0; m < CHANNELS; m++) walk_pos[m] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // leave idle, four forward steps, repeat, reverse through zero
    idle_pct = 10;
    offer(OP_SAMPLE, 8'h00, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'hAA, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'hFF, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h55, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h00, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h00, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h55, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'hFF, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'hAA, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h00, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h55, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'hFF, 2'($urandom), 1'($urandom));
    // two-step jump, then leave idle again
    offer(OP_SAMPLE, 8'h00, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h00, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h1E, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'h78, 2'($urandom), 1'($urandom));
    // channel resets, with and without clearing
    offer(OP_RESET, 8'hFF, 2'd0, 1'b1);
    offer(OP_RESET, 8'h00, 2'd1, 1'b0);
    offer(OP_RESET, 8'h5A, 2'd2, 1'b1);
    offer(OP_RESET, 8'hA5, 2'd3, 1'b0);
    offer(OP_SAMPLE, 8'h78, 2'($urandom), 1'($urandom));
    offer(OP_SAMPLE, 8'hE1, 2'($urandom), 1'($urandom));

    // long receiver hold-off while items keep coming
    idle_pct = 0;
    hold_req = 1'b1;
    for (n = 0; n < 20; n++) offer(OP_SAMPLE, 8'($urandom), 2'($urandom), 1'($urandom));

    for (seg = 0; seg < 5; seg++) begin
      case (seg)
        0: idle_pct = 15;
        1: idle_pct = 0;
        2: idle_pct = 40;
        3: idle_pct = 8;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < SEG_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          offer(OP_RESET, 8'($urandom), 2'($urandom), 1'($urandom));
        end else if (r < 10) begin
          offer(OP_SAMPLE, 8'($urandom), 2'($urandom), 1'($urandom));
        end else begin
          for (m = 0; m < CHANNELS; m++) begin
            r = $urandom_range(0, 99);
            if (r < 40) walk_pos[m] = walk_pos[m] + 2'd1;
            else if (r < 65) walk_pos[m] = walk_pos[m] - 2'd1;
            else if (r >= 92) walk_pos[m] = walk_pos[m] + 2'd2;
            pins[2*m +: 2] = {walk_pos[m][1] ^ walk_pos[m][0], walk_pos[m][1]};
          end
          offer(OP_SAMPLE, pins, 2'($urandom), 1'($urandom));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
